[rtl/sbt_pkg.sv]
// Shared request codes, field widths and result layout for the sparse bit set table.
`default_nettype none
package sbt_pkg;
    localparam logic [2:0] REQ_WRITE   = 3'd0;
    localparam logic [2:0] REQ_READ    = 3'd1;
    localparam logic [2:0] REQ_CLEAR   = 3'd2;
    localparam logic [2:0] REQ_RESTART = 3'd3;
    localparam logic [2:0] REQ_NEXT    = 3'd4;
    localparam logic [2:0] REQ_COUNT   = 3'd5;

    localparam int IDX_W  = 12;
    localparam int CNT_W  = 13;
    localparam int IN_W   = 16;
    localparam int OUT_W  = 32;

    // Listed from the highest bit down, so read_bit lands in bit 0
    typedef struct packed {
        logic             out_of_range;
        logic             is_empty;
        logic [CNT_W-1:0] set_count;
        logic [IDX_W-1:0] next_position;
        logic             found;
        logic             read_bit;
    } result_t;
endpackage
`default_nettype wire

[rtl/sparse_bitset_table_top.sv]
// Sparse bit set kept as a sorted table of nonzero blocks, with a sequenced shared datapath.
//
// The block takes one request at a time on s_axis and returns one result on m_axis.
// The table is a pair of memories (block number and block word) of MAX_BLOCKS entries,
// each with one read and one write port, and a small sequencer walks it one entry at a
// time, a read and then its data (ST_SCAN, ST_SCANW). A lookup scans from entry 0 up to
// the match. An insert or a removal then shifts the tail one entry at a time (read,
// write). A count reads every stored block and adds its population count. A next set
// bit request reads at most two blocks and searches one word one bit per cycle.
// Clear, restart and unused codes go straight to the result. No clearing pass is needed
// after reset. tready is low while a request is in work or a result waits;
// the result sits in an output register until taken.
`default_nettype none
module sparse_bitset_table_top #(
    parameter int MAX_BITS   = 4096,
    parameter int BLOCK_BITS = 64,
    parameter int MAX_BLOCKS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    // [2:0] req_type, [14:3] bit position, [15] bit_value
    input  wire logic [15:0] s_axis_tdata,
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] read_bit, [1] found, [13:2] next_position, [26:14] set_count,
    // [27] is_empty, [28] out_of_range, [31:29] zero
    output      logic [31:0] m_axis_tdata,
    input  wire logic        cfg_we,
    input  wire logic [12:0] cfg_wdata
);
    import sbt_pkg::*;

    localparam int BW   = $clog2(BLOCK_BITS);
    localparam int AW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int NW   = (MAX_BITS / BLOCK_BITS > 1) ? $clog2(MAX_BITS / BLOCK_BITS) : 1;
    localparam int SW   = $clog2(MAX_BLOCKS + 1);
    localparam int CBW  = $clog2(BLOCK_BITS + 1);
    localparam int PW   = $clog2(MAX_BITS) + 1;
    localparam int PCW  = $clog2(BLOCK_BITS + 1);
    localparam int ACCW = $clog2(MAX_BITS + 1) + 1;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SCAN   = 4'd1;
    localparam logic [3:0] ST_SCANW  = 4'd2;
    localparam logic [3:0] ST_HIT    = 4'd3;
    localparam logic [3:0] ST_INSR   = 4'd4;
    localparam logic [3:0] ST_INSW   = 4'd5;
    localparam logic [3:0] ST_REMR   = 4'd6;
    localparam logic [3:0] ST_REMW   = 4'd7;
    localparam logic [3:0] ST_CNT    = 4'd8;
    localparam logic [3:0] ST_NXRD   = 4'd9;
    localparam logic [3:0] ST_NXSRCH = 4'd10;
    localparam logic [3:0] ST_DONE   = 4'd11;
    localparam logic [3:0] ST_NXWAIT = 4'd12;
    localparam logic [3:0] ST_WRBACK = 4'd13;

    // Table memories
    logic [NW-1:0]         num_mem  [MAX_BLOCKS];
    logic [BLOCK_BITS-1:0] word_mem [MAX_BLOCKS];
    logic [NW-1:0]         num_rd;
    logic [BLOCK_BITS-1:0] word_rd;
    logic                  mem_we;
    logic [AW-1:0]         mem_wa, mem_ra;
    logic [NW-1:0]         mem_wnum;
    logic [BLOCK_BITS-1:0] mem_wword;

    logic [3:0]            state_reg, state_next;
    logic [12:0]           usize_reg;
    logic [SW-1:0]         stored_reg, stored_next;
    logic [SW-1:0]         cblk_reg, cblk_next;
    logic [CBW-1:0]        cbit_reg, cbit_next;
    logic [SW-1:0]         ptr_reg, ptr_next;
    logic [2:0]            type_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic                  val_reg;
    logic [NW-1:0]         hnum_reg, hnum_next;
    logic [BLOCK_BITS-1:0] hword_reg, hword_next;
    logic [BW-1:0]         sbit_reg, sbit_next;
    logic                  second_reg, second_next;
    logic [ACCW-1:0]       acc_reg, acc_next;
    result_t               res_reg, res_next;
    logic                  ovalid_reg, ovalid_next;

    logic                  in_xfer;
    logic [PW-1:0]         limit;
    logic [IDX_W-BW-1:0]   want_num;
    logic [BW-1:0]         want_bit;
    logic [PCW-1:0]        pcnt;
    logic [PW-1:0]         cand_pos;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && !ovalid_reg;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {3'b000, res_reg};
    assign limit    = (usize_reg < 13'(MAX_BITS)) ? PW'(usize_reg) : PW'(MAX_BITS);
    assign want_num = idx_reg[IDX_W-1:BW];
    assign want_bit = idx_reg[BW-1:0];
    assign cand_pos = PW'({hnum_reg, sbit_reg});

    // Population count of the held word
    always_comb
    begin
        pcnt = '0;
        for (int i = 0; i < BLOCK_BITS; i++)
            pcnt = pcnt + PCW'(hword_reg[i]);
    end

    // Memory ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            num_mem[mem_wa]  <= mem_wnum;
            word_mem[mem_wa] <= mem_wword;
        end
        num_rd  <= num_mem[mem_ra];
        word_rd <= word_mem[mem_ra];
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        stored_next = stored_reg;
        cblk_next   = cblk_reg;
        cbit_next   = cbit_reg;
        ptr_next    = ptr_reg;
        hnum_next   = hnum_reg;
        hword_next  = hword_reg;
        sbit_next   = sbit_reg;
        second_next = second_reg;
        acc_next    = acc_reg;
        res_next    = res_reg;
        ovalid_next = ovalid_reg;
        mem_we      = 1'b0;
        mem_wa      = ptr_reg[AW-1:0];
        mem_ra      = ptr_reg[AW-1:0];
        mem_wnum    = hnum_reg;
        mem_wword   = hword_reg;

        if (ovalid_reg && m_axis_tready)
            ovalid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    res_next  = '0;
                    ptr_next  = '0;
                    acc_next  = '0;
                    unique case (s_axis_tdata[2:0])
                        REQ_WRITE, REQ_READ:
                        begin
                            if (PW'(s_axis_tdata[14:3]) >= limit)
                            begin
                                res_next.out_of_range = 1'b1;
                                state_next = ST_DONE;
                            end
                            else
                                state_next = ST_SCAN;
                        end
                        REQ_CLEAR:
                        begin
                            stored_next = '0;
                            state_next  = ST_DONE;
                        end
                        REQ_RESTART:
                        begin
                            cblk_next  = '0;
                            cbit_next  = '0;
                            state_next = ST_DONE;
                        end
                        REQ_NEXT:
                        begin
                            ptr_next    = cblk_reg;
                            second_next = 1'b0;
                            priority if (stored_reg == '0)
                                state_next = ST_DONE;
                            else if (cblk_reg >= stored_reg)
                            begin
                                cblk_next  = '0;
                                cbit_next  = '0;
                                state_next = ST_DONE;
                            end
                            else
                                state_next = ST_NXWAIT;
                        end
                        REQ_COUNT:
                        begin
                            // Fetch entry 0 now so its data is ready in the next state
                            mem_ra     = '0;
                            state_next = (stored_reg == '0) ? ST_DONE : ST_SCANW;
                        end
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end
            // Issue a read at ptr, data valid next cycle
            ST_SCAN:
                state_next = (ptr_reg < stored_reg) ? ST_SCANW : ST_HIT;
            ST_SCANW:
            begin
                hnum_next  = num_rd;
                hword_next = word_rd;
                if (type_reg == REQ_COUNT)
                    state_next = ST_CNT;
                else if (NW'(want_num) > num_rd)
                begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = ST_SCAN;
                end
                else
                    state_next = ST_HIT;
            end
            // ptr is the lower bound; hold entry is valid if ptr < stored
            ST_HIT:
            begin
                if (ptr_reg < stored_reg && hnum_reg == NW'(want_num))
                begin
                    if (type_reg == REQ_READ)
                    begin
                        res_next.read_bit = hword_reg[want_bit];
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        hword_next = hword_reg;
                        hword_next[want_bit] = val_reg;
                        state_next = ST_WRBACK;
                    end
                end
                else if (type_reg == REQ_WRITE && val_reg
                         && stored_reg < SW'(MAX_BLOCKS))
                begin
                    // Shift tail up starting from the last entry
                    sbit_next  = '0;
                    ptr_next   = stored_reg;
                    acc_next   = ACCW'(ptr_reg);
                    state_next = ST_INSR;
                end
                else
                    state_next = ST_DONE;
            end
            ST_WRBACK:
            begin
                if (hword_reg == '0)
                begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = ST_REMR;
                end
                else
                begin
                    mem_we     = 1'b1;
                    state_next = ST_DONE;
                end
            end
            // Insert: move entry ptr-1 to ptr until ptr reaches the slot
            ST_INSR:
            begin
                if (ptr_reg == SW'(acc_reg))
                begin
                    mem_we       = 1'b1;
                    mem_wnum     = NW'(want_num);
                    mem_wword    = '0;
                    mem_wword[want_bit] = 1'b1;
                    stored_next  = stored_reg + 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    mem_ra     = AW'(ptr_reg - 1'b1);
                    state_next = ST_INSW;
                end
            end
            ST_INSW:
            begin
                mem_we     = 1'b1;
                mem_wnum   = num_rd;
                mem_wword  = word_rd;
                ptr_next   = ptr_reg - 1'b1;
                state_next = ST_INSR;
            end
            // Remove: move entry ptr to ptr-1 until the end
            ST_REMR:
            begin
                if (ptr_reg >= stored_reg)
                begin
                    stored_next = stored_reg - 1'b1;
                    state_next  = ST_DONE;
                end
                else
                    state_next = ST_REMW;
            end
            ST_REMW:
            begin
                mem_we     = 1'b1;
                mem_wa     = AW'(ptr_reg - 1'b1);
                mem_wnum   = num_rd;
                mem_wword  = word_rd;
                ptr_next   = ptr_reg + 1'b1;
                mem_ra     = AW'(ptr_reg + 1'b1);
                state_next = ST_REMR;
            end
            // Count: add the held block, read the next
            ST_CNT:
            begin
                acc_next = acc_reg + ACCW'(pcnt);
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg + 1'b1 >= stored_reg)
                begin
                    res_next.set_count = CNT_W'(acc_reg + ACCW'(pcnt));
                    state_next = ST_DONE;
                end
                else
                begin
                    mem_ra     = AW'(ptr_reg + 1'b1);
                    state_next = ST_SCANW;
                end
            end
            // Next: read addressed block
            ST_NXWAIT:
                state_next = ST_NXRD;
            ST_NXRD:
            begin
                hnum_next  = num_rd;
                hword_next = word_rd;
                if (!second_reg)
                begin
                    if (cbit_reg >= CBW'(BLOCK_BITS) || (word_rd >> cbit_reg) == '0)
                    begin
                        second_next = 1'b1;
                        ptr_next    = ptr_reg + 1'b1;
                        if (ptr_reg + 1'b1 >= stored_reg)
                        begin
                            cblk_next  = '0;
                            cbit_next  = '0;
                            state_next = ST_DONE;
                        end
                        else
                            state_next = ST_NXWAIT;
                    end
                    else
                    begin
                        sbit_next  = BW'(cbit_reg);
                        state_next = ST_NXSRCH;
                    end
                end
                else
                begin
                    sbit_next  = '0;
                    state_next = ST_NXSRCH;
                end
            end
            ST_NXSRCH:
            begin
                if (hword_reg[sbit_reg])
                begin
                    if (cand_pos < limit)
                    begin
                        cblk_next = ptr_reg;
                        cbit_next = CBW'(sbit_reg) + 1'b1;
                        res_next.found = 1'b1;
                        res_next.next_position = IDX_W'(cand_pos);
                    end
                    state_next = ST_DONE;
                end
                else if (sbit_reg == BW'(BLOCK_BITS - 1))
                begin
                    cblk_next  = '0;
                    cbit_next  = '0;
                    state_next = ST_DONE;
                end
                else
                    sbit_next = sbit_reg + 1'b1;
            end
            ST_DONE:
            begin
                res_next.is_empty = (stored_reg == '0);
                ovalid_next = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            usize_reg  <= 13'd4096;
            stored_reg <= '0;
            cblk_reg   <= '0;
            cbit_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            stored_reg <= stored_next;
            cblk_reg   <= cblk_next;
            cbit_reg   <= cbit_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we)
                usize_reg <= cfg_wdata;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            type_reg <= s_axis_tdata[2:0];
            idx_reg  <= s_axis_tdata[14:3];
            val_reg  <= s_axis_tdata[15];
        end
        ptr_reg    <= ptr_next;
        hnum_reg   <= hnum_next;
        hword_reg  <= hword_next;
        sbit_reg   <= sbit_next;
        second_reg <= second_next;
        acc_reg    <= acc_next;
        res_reg    <= res_next;
    end

    // Checks
    a_stored_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stored_reg <= SW'(MAX_BLOCKS)) else $error("table overfilled");
    a_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |=> m_axis_tvalid) else $error("result lost");
    a_found_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && res_reg.found) |-> !res_reg.out_of_range)
        else $error("found with range flag");
endmodule
`default_nettype wire

[bench/sparse_bitset_table_top_test.sv]
// Self-checking testbench for the sparse bit set table: predicts every result and compares.
`default_nettype none
module sparse_bitset_table_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import sbt_pkg::*;

    localparam int BLK_BITS = 64;
    localparam int BLK_MAX  = 64;
    localparam int SIZE_MAX = 4096;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        cfg_we;
    logic [12:0] cfg_wdata;

    sparse_bitset_table_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    // Shadow copy of the table, cursor and size register
    logic [5:0]  shadow_num [BLK_MAX];
    logic [63:0] shadow_word [BLK_MAX];
    int unsigned shadow_blocks;
    int unsigned cur_block;
    int unsigned cur_bit;
    logic [12:0] shadow_size;

    result_t     pending_results[$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Keep the table model in step with one request and return its result
    function automatic result_t predict_result(logic [2:0] kind, logic [11:0] idx,
                                               logic val);
        result_t     r;
        int unsigned lim;
        int unsigned num;
        int unsigned bitn;
        int unsigned p;
        int unsigned cb;
        int unsigned cbit;
        int unsigned b;
        int unsigned pos;
        int unsigned cnt;
        bit          hit;
        logic [63:0] w;
        r = '0;
        lim = (shadow_size < SIZE_MAX) ? shadow_size : SIZE_MAX;
        if (kind == REQ_WRITE || kind == REQ_READ)
        begin
            if (idx >= lim)
                r.out_of_range = 1'b1;
            else
            begin
                num = idx / BLK_BITS;
                bitn = idx % BLK_BITS;
                p = 0;
                while (p < shadow_blocks && shadow_num[p] < num)
                    p++;
                hit = (p < shadow_blocks) && (shadow_num[p] == num);
                if (kind == REQ_READ)
                begin
                    if (hit)
                        r.read_bit = shadow_word[p][bitn];
                end
                else if (val)
                begin
                    if (!hit && shadow_blocks < BLK_MAX)
                    begin
                        for (int k = shadow_blocks; k > p; k--)
                        begin
                            shadow_num[k] = shadow_num[k-1];
                            shadow_word[k] = shadow_word[k-1];
                        end
                        shadow_num[p] = num[5:0];
                        shadow_word[p] = '0;
                        shadow_blocks++;
                        hit = 1'b1;
                    end
                    if (hit)
                        shadow_word[p][bitn] = 1'b1;
                end
                else if (hit)
                begin
                    shadow_word[p][bitn] = 1'b0;
                    if (shadow_word[p] == '0)
                    begin
                        for (int k = p; k + 1 < shadow_blocks; k++)
                        begin
                            shadow_num[k] = shadow_num[k+1];
                            shadow_word[k] = shadow_word[k+1];
                        end
                        shadow_blocks--;
                    end
                end
            end
        end
        else if (kind == REQ_CLEAR)
            shadow_blocks = 0;
        else if (kind == REQ_RESTART)
        begin
            cur_block = 0;
            cur_bit = 0;
        end
        else if (kind == REQ_NEXT)
        begin
            if (shadow_blocks != 0)
            begin
                if (cur_block >= shadow_blocks)
                begin
                    cur_block = 0;
                    cur_bit = 0;
                end
                else
                begin
                    cb = cur_block;
                    cbit = cur_bit;
                    w = shadow_word[cb];
                    if (cbit >= BLK_BITS || (w >> cbit) == 0)
                    begin
                        cb++;
                        cbit = 0;
                    end
                    if (cb >= shadow_blocks)
                    begin
                        cur_block = 0;
                        cur_bit = 0;
                    end
                    else
                    begin
                        w = shadow_word[cb];
                        b = cbit;
                        while (b < BLK_BITS && !w[b])
                            b++;
                        if (b >= BLK_BITS)
                        begin
                            cur_block = 0;
                            cur_bit = 0;
                        end
                        else
                        begin
                            pos = shadow_num[cb] * BLK_BITS + b;
                            if (pos < lim)
                            begin
                                cur_block = cb;
                                cur_bit = b + 1;
                                r.found = 1'b1;
                                r.next_position = pos[11:0];
                            end
                        end
                    end
                end
            end
        end
        else if (kind == REQ_COUNT)
        begin
            cnt = 0;
            for (int k = 0; k < shadow_blocks; k++)
                cnt += $countones(shadow_word[k]);
            r.set_count = cnt[12:0];
        end
        r.is_empty = (shadow_blocks == 0);
        return r;
    endfunction

    // Send one request and queue its expected result; tvalid stays high on return
    task automatic send_request(logic [2:0] kind, logic [11:0] idx, logic val);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {val, idx, kind};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results.insert(pending_results.size(), predict_result(kind, idx, val));
    endtask

    // Drop the request line and wait until every result is back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_size(logic [12:0] value);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_size = value;
    endtask

    // Receive side: random stall, compare each transfer with the oldest expectation
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[28:0];
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", m_axis_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want || m_axis_tdata[31:29] !== 3'b000)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: expected rb=%0d f=%0d pos=%0d cnt=%0d e=%0d oor=%0d",
                            want.read_bit, want.found, want.next_position, want.set_count,
                            want.is_empty, want.out_of_range);
                        $display("          got      rb=%0d f=%0d pos=%0d cnt=%0d e=%0d oor=%0d",
                            got.read_bit, got.found, got.next_position, got.set_count,
                            got.is_empty, got.out_of_range);
                    end
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic test_directed();
        send_request(REQ_NEXT, 12'd0, 1'b0);        // enumeration on empty table
        send_request(REQ_COUNT, 12'd0, 1'b0);
        send_request(REQ_WRITE, 12'd0, 1'b0);       // clear in absent block
        send_request(REQ_WRITE, 12'd4095, 1'b1);
        send_request(REQ_WRITE, 12'd0, 1'b1);
        send_request(REQ_WRITE, 12'd63, 1'b1);
        send_request(REQ_WRITE, 12'd64, 1'b1);
        send_request(REQ_READ, 12'd63, 1'b0);
        send_request(REQ_READ, 12'd4095, 1'b0);
        send_request(REQ_READ, 12'd1000, 1'b0);
        send_request(REQ_COUNT, 12'd0, 1'b0);
        send_request(REQ_RESTART, 12'd0, 1'b0);
        for (int k = 0; k < 5; k++)                 // steps past bit 63 and wraps
            send_request(REQ_NEXT, 12'd0, 1'b0);
        send_request(REQ_WRITE, 12'd64, 1'b0);      // removes a block
        send_request(3'd6, 12'hfff, 1'b1);          // unused codes
        send_request(3'd7, 12'h000, 1'b0);
        send_request(REQ_CLEAR, 12'd0, 1'b0);
        send_request(REQ_NEXT, 12'd0, 1'b0);        // enumeration on cleared table
        write_size(13'd100);
        send_request(REQ_WRITE, 12'd100, 1'b1);     // out of range
        send_request(REQ_WRITE, 12'd99, 1'b1);
        write_size(13'd50);
        send_request(REQ_NEXT, 12'd0, 1'b0);        // position beyond limit
    endtask

    // Fill every block so the table-full case is reached
    task automatic test_table_full();
        write_size(13'd4096);
        for (int k = 0; k < 64; k++)
            send_request(REQ_WRITE, 12'(k * 64 + $urandom_range(63)), 1'b1);
        send_request(REQ_WRITE, 12'd5, 1'b1);
        send_request(REQ_COUNT, 12'd0, 1'b0);
        send_request(REQ_CLEAR, 12'd0, 1'b0);
    endtask

    task automatic test_random(int count);
        logic [2:0]  kind;
        logic [11:0] idx;
        int          r;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            if (r < 40) kind = REQ_WRITE;
            else if (r < 55) kind = REQ_READ;
            else if (r < 57) kind = REQ_CLEAR;
            else if (r < 62) kind = REQ_RESTART;
            else if (r < 90) kind = REQ_NEXT;
            else if (r < 97) kind = REQ_COUNT;
            else kind = 3'($urandom_range(7, 6));
            // mostly a few blocks so enumeration finds hits
            if ($urandom_range(3) == 0)
                idx = 12'($urandom);
            else
                idx = 12'($urandom_range(5) * 64 + $urandom_range(63));
            send_request(kind, idx, ($urandom_range(99) < 60));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        mismatches = 0;
        shadow_blocks = 0;
        cur_block = 0;
        cur_bit = 0;
        shadow_size = 13'd4096;
        send_idle_pct = 32;
        recv_idle_pct = 70;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_table_full();
        write_size(13'd0);
        test_random(100);
        write_size(13'd4096);
        test_random(500);
        // hold off until all results are back
        wait_drained();
        send_idle_pct = 70;
        recv_idle_pct = 32;
        write_size(13'd1500);
        test_random(500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_size(13'd4095);
        test_random(600);
        wait_drained();
        repeat (200) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
rtl/sbt_pkg.sv
rtl/sparse_bitset_table_top.sv
bench/sparse_bitset_table_top_test.sv
